// ===== src/mvhm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvhm_pkg
// shared types and constants of the motion vector history map
// ----------------------------------------------------------------------------
package mvhm_pkg;

	localparam int unsigned CfgIdxW      = 1;
	localparam logic [0:0]  RegCellCount = 1'b0;
	localparam logic [0:0]  RegCooldown  = 1'b1;

	localparam logic [12:0] CellCountRst = 13'd3645;
	localparam logic [15:0] CooldownRst  = 16'd90;
	localparam logic [16:0] CounterMax   = 17'd131071;
	localparam logic [7:0]  LevelScale   = 8'd255;
	localparam logic [7:0]  LevelCut     = 8'd3;

	localparam logic OpVector = 1'b0;
	localparam logic OpRead   = 1'b1;

	localparam logic KindSummary = 1'b0;
	localparam logic KindRead    = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VREAD,
		ST_VWRITE,
		ST_RREAD,
		ST_RREPLY,
		ST_PREAD,
		ST_PLOAD,
		ST_PDIV,
		ST_PWRITE,
		ST_SUMMARY
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_write;   // write zero at cursor, step cursor
		logic vec_capture; // latch input item
		logic vec_read;    // read history at cell cursor
		logic vec_write;   // write updated history, step cursor / min-max
		logic rd_read;     // read both stores at read index
		logic rd_reply;
		logic pass_start;
		logic pass_read;   // read history at pass index
		logic pass_load;   // start divider for current cell
		logic pass_write;  // write level, step pass index
		logic summary;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic vec_last;
		logic div_done;
		logic pass_last;
	} stat_t;

endpackage

// ===== src/mvhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mvhm_ctrl
// sequencer for vector load, cell read, level pass and reset clear
// ----------------------------------------------------------------------------
module mvhm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            opcode,
	output logic            busy,
	output mvhm_pkg::cmd_t  cmd,
	input  mvhm_pkg::stat_t stat
);

	mvhm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mvhm_pkg::ST_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mvhm_pkg::ST_CLEAR:   if (stat.clr_done) state_d = mvhm_pkg::ST_IDLE;
			mvhm_pkg::ST_IDLE: begin
				if (start)
					state_d = (opcode == mvhm_pkg::OpRead) ? mvhm_pkg::ST_RREAD
					                                       : mvhm_pkg::ST_VREAD;
			end
			mvhm_pkg::ST_VREAD:   state_d = mvhm_pkg::ST_VWRITE;
			mvhm_pkg::ST_VWRITE:  state_d = stat.vec_last ? mvhm_pkg::ST_PREAD
			                                              : mvhm_pkg::ST_IDLE;
			mvhm_pkg::ST_RREAD:   state_d = mvhm_pkg::ST_RREPLY;
			mvhm_pkg::ST_RREPLY:  state_d = mvhm_pkg::ST_IDLE;
			mvhm_pkg::ST_PREAD:   state_d = mvhm_pkg::ST_PLOAD;
			mvhm_pkg::ST_PLOAD:   state_d = mvhm_pkg::ST_PDIV;
			mvhm_pkg::ST_PDIV:    if (stat.div_done) state_d = mvhm_pkg::ST_PWRITE;
			mvhm_pkg::ST_PWRITE:  state_d = stat.pass_last ? mvhm_pkg::ST_SUMMARY
			                                               : mvhm_pkg::ST_PREAD;
			mvhm_pkg::ST_SUMMARY: state_d = mvhm_pkg::ST_IDLE;
			default:              state_d = mvhm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			mvhm_pkg::ST_CLEAR:   cmd.clr_write = 1'b1;
			mvhm_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.vec_capture = start;
			end
			mvhm_pkg::ST_VREAD:   cmd.vec_read = 1'b1;
			mvhm_pkg::ST_VWRITE: begin
				cmd.vec_write  = 1'b1;
				cmd.pass_start = stat.vec_last;
			end
			mvhm_pkg::ST_RREAD:   cmd.rd_read = 1'b1;
			mvhm_pkg::ST_RREPLY:  cmd.rd_reply = 1'b1;
			mvhm_pkg::ST_PREAD:   cmd.pass_read = 1'b1;
			mvhm_pkg::ST_PLOAD:   cmd.pass_load = 1'b1;
			mvhm_pkg::ST_PDIV:    ;
			mvhm_pkg::ST_PWRITE:  cmd.pass_write = 1'b1;
			mvhm_pkg::ST_SUMMARY: cmd.summary = 1'b1;
			default:              ;
		endcase
	end

endmodule

// ===== src/mvhm_datapath.sv =====
// ----------------------------------------------------------------------------
// mvhm_datapath
// history and level stores, min/max tracking, bit-serial level divider
// ----------------------------------------------------------------------------
module mvhm_datapath #(
	parameter int unsigned MAX_CELLS    = 4096,
	parameter int unsigned HISTORY_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mvhm_pkg::cmd_t  cmd,
	output mvhm_pkg::stat_t stat,
	input  logic [12:0]     cell_count,
	input  logic [15:0]     cooldown_frames,
	input  logic [7:0]      vec_x,
	input  logic [7:0]      vec_y,
	input  logic [11:0]     read_index,
	output logic            res_valid,
	output logic            reply_kind,
	output logic [12:0]     active_points,
	output logic            report_enabled,
	output logic [7:0]      motion_level,
	output logic            newest_motion
);

	localparam int unsigned AW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int unsigned CW  = $clog2(MAX_CELLS + 1);
	localparam int unsigned HB  = HISTORY_BITS;
	localparam int unsigned PCW = $clog2(HISTORY_BITS + 1);

	logic [HB-1:0] hist_mem [MAX_CELLS];
	logic [7:0]    lvl_mem  [MAX_CELLS];

	logic [CW-1:0] n_eff;
	always_comb begin
		if (cell_count == '0) n_eff = CW'(1);
		else if ({19'd0, cell_count} > 32'(MAX_CELLS)) n_eff = CW'(MAX_CELLS);
		else n_eff = CW'(cell_count);
	end

	logic [CW-1:0] cursor_q, pidx_q;
	logic          nz_q;
	logic [AW-1:0] ridx_q;
	logic          rok_q;
	logic [HB-1:0] hrd_q;
	logic [7:0]    lrd_q;
	logic [HB-1:0] min_q, max_q, range_q;
	logic [16:0]   fcnt_q;
	logic          en_q;
	logic [12:0]   active_q;

	// memory write port mux
	logic          hwe, lwe;
	logic [AW-1:0] hwa, lwa, hra;
	logic [HB-1:0] hwd, hnew;
	logic [7:0]    lwd;
	logic [7:0]    level;
	logic          lvl_nz;

	assign hnew = {nz_q, hrd_q[HB-1:1]};

	always_comb begin
		hwe = cmd.clr_write | cmd.vec_write;
		hwa = cursor_q[AW-1:0];
		hwd = cmd.clr_write ? '0 : hnew;
		lwe = cmd.clr_write | cmd.pass_write;
		lwa = cmd.clr_write ? cursor_q[AW-1:0] : pidx_q[AW-1:0];
		lwd = cmd.clr_write ? 8'd0 : level;
		if (cmd.rd_read)        hra = ridx_q;
		else if (cmd.pass_read) hra = pidx_q[AW-1:0];
		else                    hra = cursor_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (hwe) hist_mem[hwa] <= hwd;
		if (lwe) lvl_mem[lwa] <= lwd;
		hrd_q <= hist_mem[hra];
		lrd_q <= lvl_mem[ridx_q];
	end

	assign stat.clr_done  = cmd.clr_write && (cursor_q == CW'(MAX_CELLS - 1));
	assign stat.vec_last  = (cursor_q + CW'(1)) >= n_eff;
	assign stat.pass_last = (pidx_q + CW'(1)) >= n_eff;

	// level divider: f = floor(256*d/r), one quotient bit per cycle
	logic [HB:0]   rem_q;
	logic [HB-1:0] d_q;
	logic [7:0]    f_q;
	logic [3:0]    dcnt_q;
	logic          sat_q, skip_q;
	logic [PCW-1:0] pop;

	always_comb begin
		pop = '0;
		for (int i = 0; i < HB; i++) pop = pop + PCW'(hrd_q[i]);
	end

	assign stat.div_done = (dcnt_q == 4'd8);

	logic [HB:0] rdiff;
	assign rdiff = {1'b0, range_q} - rem_q;

	always_comb begin
		logic [7:0] raw;
		if (skip_q)                raw = 8'd0;
		else if (sat_q)            raw = mvhm_pkg::LevelScale;
		else if (rem_q >= {1'b0, d_q}) raw = f_q;
		else                       raw = f_q - 8'd1;
		level  = (raw < mvhm_pkg::LevelCut) ? 8'd0 : raw;
		lvl_nz = (level != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			pidx_q    <= '0;
			min_q     <= '1;
			max_q     <= '0;
			range_q   <= '0;
			fcnt_q    <= '0;
			en_q      <= 1'b0;
			active_q  <= '0;
			res_valid <= 1'b0;
			dcnt_q    <= '0;
			rem_q     <= '0;
			d_q       <= '0;
			f_q       <= '0;
			sat_q     <= 1'b0;
			skip_q    <= 1'b0;
		end else begin
			res_valid <= cmd.rd_reply | cmd.summary;
			if (cmd.clr_write)
				cursor_q <= stat.clr_done ? '0 : cursor_q + CW'(1);
			if (cmd.vec_capture && cursor_q >= CW'(MAX_CELLS))
				cursor_q <= '0;
			if (cmd.vec_write) begin
				if (hnew > max_q) max_q <= hnew;
				if (hnew < min_q) min_q <= hnew;
				cursor_q <= stat.vec_last ? '0 : cursor_q + CW'(1);
			end
			if (cmd.pass_start) begin
				pidx_q   <= '0;
				active_q <= '0;
				range_q  <= ((hnew > max_q ? hnew : max_q) - (hnew < min_q ? hnew : min_q));
			end
			if (cmd.pass_load) begin
				dcnt_q <= '0;
				f_q    <= '0;
				d_q    <= hrd_q - min_q;
				rem_q  <= {1'b0, hrd_q - min_q};
				skip_q <= (pop <= PCW'(2)) || (range_q == '0) || (hrd_q <= min_q);
				sat_q  <= (hrd_q - min_q) >= range_q;
			end else if (dcnt_q != 4'd8 && !cmd.pass_write) begin
				dcnt_q <= dcnt_q + 4'd1;
				if (rem_q >= rdiff) begin
					rem_q <= rem_q - rdiff;
					f_q   <= {f_q[6:0], 1'b1};
				end else begin
					rem_q <= rem_q + rem_q;
					f_q   <= {f_q[6:0], 1'b0};
				end
			end
			if (cmd.pass_write) begin
				pidx_q <= pidx_q + CW'(1);
				if (lvl_nz) active_q <= active_q + 13'd1;
			end
			if (cmd.summary) begin
				if (fcnt_q < mvhm_pkg::CounterMax) fcnt_q <= fcnt_q + 17'd1;
				if (!en_q && ({1'b0, cooldown_frames} < fcnt_q + 17'd1)) en_q <= 1'b1;
				min_q <= '1;
				max_q <= '0;
			end
		end
	end

	// first-pass min/max lag: at pass_start the last cell is folded in above
	// via range_q; min_q/max_q update the same edge so the pass sees them

	always_ff @(posedge clk) begin
		if (cmd.vec_capture) begin
			nz_q   <= (vec_x != 8'd0) || (vec_y != 8'd0);
			rok_q  <= 32'(read_index) < 32'(MAX_CELLS);
			ridx_q <= AW'(read_index);
		end
	end

	// report_enabled takes en_q before the summary edge updates it
	always_ff @(posedge clk) begin
		reply_kind     <= cmd.rd_reply ? mvhm_pkg::KindRead : mvhm_pkg::KindSummary;
		active_points  <= cmd.summary ? active_q : 13'd0;
		report_enabled <= cmd.summary ? en_q : 1'b0;
		motion_level   <= (cmd.rd_reply && rok_q) ? lrd_q : 8'd0;
		newest_motion  <= (cmd.rd_reply && rok_q) ? hrd_q[HB-1] : 1'b0;
	end

endmodule

// ===== src/mvhm_cfg.sv =====
// ----------------------------------------------------------------------------
// mvhm_cfg
// configuration register file
// ----------------------------------------------------------------------------
module mvhm_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [mvhm_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [15:0] cfg_data,
	output logic [12:0] cell_count,
	output logic [15:0] cooldown_frames
);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count      <= mvhm_pkg::CellCountRst;
			cooldown_frames <= mvhm_pkg::CooldownRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mvhm_pkg::RegCellCount: cell_count      <= cfg_data[12:0];
				mvhm_pkg::RegCooldown:  cooldown_frames <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/motion_vector_history_map.sv =====
// ----------------------------------------------------------------------------
// motion_vector_history_map
// per-cell motion history with end-of-frame level normalization
// ----------------------------------------------------------------------------
// vector item: capture, read and write of its cell; the last vector of a frame adds a
// pass over the frame's cells (read, load, 8 quotient steps in the divider, write) plus a summary
// read item: read of both stores, then a registered reply strobe; one item at a time
// after reset both stores are cleared, with busy high
// results are strobed for one cycle; the receiver cannot stall
module motion_vector_history_map #(
	parameter int unsigned MAX_CELLS    = 4096,
	parameter int unsigned HISTORY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic signed [7:0] vec_x,
	input  logic signed [7:0] vec_y,
	input  logic [11:0] read_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [mvhm_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic        reply_kind,
	output logic [12:0] active_points,
	output logic        report_enabled,
	output logic [7:0]  motion_level,
	output logic        newest_motion
);

	mvhm_pkg::cmd_t  cmd;
	mvhm_pkg::stat_t stat;
	logic [12:0] cell_count;
	logic [15:0] cooldown_frames;

	mvhm_cfg u_cfg (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.cell_count, .cooldown_frames
	);

	mvhm_ctrl u_ctrl (
		.clk, .arst_n, .start, .opcode, .busy, .cmd, .stat
	);

	mvhm_datapath #(
		.MAX_CELLS   (MAX_CELLS),
		.HISTORY_BITS(HISTORY_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .stat, .cell_count, .cooldown_frames,
		.vec_x(vec_x), .vec_y(vec_y), .read_index,
		.res_valid(done), .reply_kind, .active_points, .report_enabled,
		.motion_level, .newest_motion
	);

endmodule
